// ===== hw/rtl/dsched_pkg.sv =====
// shared types and constants for the disk request scheduler
package dsched_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SSTF = 2'd1;
    localparam logic [1:0] POL_LOOK = 2'd2;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_DONE   = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [15:0] cylinder;
        logic [31:0] address;
        logic [15:0] process;
    } req_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] new_id;
        logic [31:0] new_arrival;
        logic [15:0] new_cylinder;
        logic [31:0] new_address;
        logic [15:0] new_process;
        logic [15:0] head_cylinder;
        logic        scan_up;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] out_id;
        logic [31:0] out_arrival;
        logic [15:0] out_cylinder;
        logic [31:0] out_address;
        logic [15:0] out_process;
        logic [4:0]  waiting_count;
        logic        dropped;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic arrive;     // perform arrival update
        logic scan_start; // clear best tracking
        logic scan_step;  // examine one entry
        logic take;       // move best entry into service
        logic shift_step; // compact one entry
        logic done_empty; // completion with empty queue
        logic finish;     // latch result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_done;
        logic queue_empty;
        logic scan_last;
        logic shift_last;
    } dp_status_t;

endpackage

// ===== hw/rtl/dsched_datapath.sv =====
// queue storage, selection scan and compaction for the disk request scheduler
module dsched_datapath #(
    parameter int QUEUE_DEPTH = dsched_pkg::QUEUE_DEPTH_DEF,
    parameter int IW = $clog2(QUEUE_DEPTH),
    parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dsched_pkg::in_beat_t   in_beat,
    input  logic [1:0]             policy,
    input  dsched_pkg::dp_cmd_t    cmd,
    output dsched_pkg::dp_status_t status,
    output dsched_pkg::out_beat_t  result
);

    dsched_pkg::req_t   mem [QUEUE_DEPTH];
    dsched_pkg::in_beat_t in_reg;
    dsched_pkg::req_t   serv_reg;
    dsched_pkg::out_beat_t res_reg;
    logic [CW-1:0]      count_reg;
    logic               drop_reg;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      best_reg;
    logic [15:0]        bd_reg;
    logic [31:0]        bts_reg;
    logic [1:0]         bgrp_reg;
    logic               found_reg;
    dsched_pkg::req_t   rd_reg;

    dsched_pkg::req_t   ent;
    logic [15:0]        c, h, d;
    logic               above, below, fwd, same;
    logic [1:0]         grp;
    logic               ok, better;
    logic [IW-1:0]      idx_next;

    always_ff @(posedge aclk) begin
        rd_reg <= mem[idx_reg];
    end

    always_comb begin
        ent   = rd_reg;
        c     = ent.cylinder;
        h     = in_reg.head_cylinder;
        above = c > h;
        below = c < h;
        same  = c == h;
        d     = above ? c - h : h - c;
        fwd   = in_reg.scan_up ? above : below;
        grp   = same ? 2'd0 : (fwd ? 2'd1 : 2'd2);
        if (policy == dsched_pkg::POL_LOOK) begin
            ok = !found_reg || grp < bgrp_reg ||
                 (grp == bgrp_reg && (d < bd_reg || (d == bd_reg && ent.arrival < bts_reg)));
        end else begin
            grp = 2'd0;
            ok  = !found_reg || d < bd_reg || (d == bd_reg && ent.arrival < bts_reg);
        end
        better = ok && (policy == dsched_pkg::POL_SSTF || policy == dsched_pkg::POL_LOOK);
        idx_next = idx_reg + 1'b1;
    end

    assign status.is_done     = in_reg.cmd == dsched_pkg::CMD_DONE;
    assign status.queue_empty = count_reg == '0;
    assign status.scan_last   = CW'(idx_reg) + 1'b1 >= count_reg;
    assign status.shift_last  = CW'(idx_reg) >= count_reg;
    assign result = res_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) in_reg <= in_beat;
        if (cmd.scan_start) begin
            idx_reg   <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.scan_step) begin
            if (better) begin
                best_reg  <= idx_reg;
                bd_reg    <= d;
                bts_reg   <= ent.arrival;
                bgrp_reg  <= grp;
                found_reg <= 1'b1;
            end
            idx_reg <= idx_next;
        end
        if (cmd.take) begin
            serv_reg <= mem[best_reg];
            idx_reg  <= best_reg;
        end
        if (cmd.shift_step) begin
            mem[idx_reg] <= mem[idx_next];
            idx_reg      <= idx_next;
        end
        if (cmd.arrive && in_reg.new_id != '0 && serv_reg.id != '0 &&
            count_reg < CW'(QUEUE_DEPTH)) begin
            mem[count_reg[IW-1:0]] <= '{in_reg.new_id, in_reg.new_arrival,
                in_reg.new_cylinder, in_reg.new_address, in_reg.new_process};
        end
        if (cmd.finish) begin
            res_reg <= '{serv_reg.id, serv_reg.arrival, serv_reg.cylinder,
                serv_reg.address, serv_reg.process, 5'(count_reg), drop_reg};
        end
        if (!aresetn) begin
            serv_reg  <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            if (cmd.load) drop_reg <= 1'b0;
            if (cmd.arrive && in_reg.new_id != '0) begin
                if (serv_reg.id == '0) begin
                    serv_reg <= '{in_reg.new_id, in_reg.new_arrival,
                        in_reg.new_cylinder, in_reg.new_address, in_reg.new_process};
                end else if (count_reg < CW'(QUEUE_DEPTH)) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.take) count_reg <= count_reg - 1'b1;
            if (cmd.done_empty) serv_reg <= '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_take_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> count_reg != '0) else $error("take from empty queue");
    a_best_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> CW'(best_reg) < count_reg) else $error("best index out of range");
`endif

endmodule

// ===== hw/rtl/dsched_ctrl.sv =====
// sequencing state machine for the disk request scheduler
module dsched_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  dsched_pkg::dp_status_t status,
    output dsched_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_TAKE  = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_PRIME = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (!status.is_done) begin
                    cmd.arrive = 1'b1;
                    state_next = ST_FIN;
                end else if (status.queue_empty) begin
                    cmd.done_empty = 1'b1;
                    state_next     = ST_FIN;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_PRIME;
                end
            end
            ST_PRIME: state_next = ST_SCAN;
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) state_next = ST_TAKE;
                else state_next = ST_PRIME;
            end
            ST_TAKE: begin
                cmd.take   = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                // count already reduced: shift while idx below count
                if (status.shift_last) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (!mv_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("second beat accepted");
    a_finish_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!mv_reg || m_ready)) else $error("result overwritten");
    a_take_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> $past(cmd.scan_step)) else $error("take without scan");
`endif

endmodule

// ===== hw/rtl/disk_request_scheduler.sv =====
// disk request scheduler: fcfs, shortest seek and look over a waiting queue
// arrival: from accept through decode and finish states to a registered result;
// completion: scans the queue entry by entry, takes the picked entry, then compacts
// the entries behind it through the queue memory port
// throughput: one beat at a time, as a new beat is accepted only in the idle state
// reset: aresetn synchronous low; clears service, queue count and drop flag, sets policy to fcfs
module disk_request_scheduler #(
    parameter int QUEUE_DEPTH = dsched_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dsched_pkg::in_beat_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dsched_pkg::out_beat_t m_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_wdata
);

    logic [1:0]             policy_reg;
    dsched_pkg::dp_cmd_t    cmd;
    dsched_pkg::dp_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) policy_reg <= dsched_pkg::POL_FCFS;
        else if (cfg_we) policy_reg <= cfg_wdata;
    end

    dsched_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .status, .cmd
    );

    dsched_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk, .aresetn, .in_beat(s_data), .policy(policy_reg),
        .cmd, .status, .result(m_data)
    );

endmodule
